/* hdl/tdrc_pkg.sv */
// Shared constants, item types and helpers for the tile decay / run-length cost block.
package tdrc_pkg;

    localparam int TILE_DIM   = 128;
    localparam int PAIR_BYTES = 2;
    localparam int THIN_RATIO = 20;

    localparam int TEXELS     = TILE_DIM * TILE_DIM;
    localparam int CNT_W      = 15;
    localparam int ENC_W      = CNT_W + 3;
    localparam int BYTE_W     = 8;
    localparam int CNT_MAX    = (1 << CNT_W) - 1;
    localparam int RUN_MAX    = (1 << BYTE_W) - 1;
    // nonzero * THIN_RATIO < TEXELS  <=>  nonzero < ceil(TEXELS / THIN_RATIO)
    localparam int THIN_LIMIT = (TEXELS + THIN_RATIO - 1) / THIN_RATIO;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] drop;
        logic [BYTE_W-1:0] texel;
    } t_texel_item;

    typedef struct packed {
        logic              stats_valid;
        logic              thin_tile;
        logic [CNT_W-1:0]  encoded_bytes;
        logic [CNT_W-1:0]  nonzero_count;
        logic              tile_alive;
        logic [BYTE_W-1:0] texel_out;
    } t_tile_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_W'(CNT_MAX)) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

/* hdl/tile_decay_rle_cost_top.sv */
// Top level of the tile decay and run-length cost block.
//
//  channel   dir  handshake            payload
//  s (item)  in   i_s_tvalid/o_s_tready  tdata: texel_in, decay_drop; tlast: last_texel
//  m (result) out o_m_tvalid/i_m_tready  tdata: texel_out .. thin_tile; tuser: stats_valid
//
// One byte per cycle sustained while the result side is not stalled; an input transaction
// reaches the result through the input register, then the result register in the core.
// The feedback loop through the run, pair and nonzero registers sets that rate.
// Synchronous active-low reset clears both valid flags and rearms tile start.
// A stall on the result side holds both stages; each stage refills in the cycle
// its successor frees, so no bubble is inserted.
module tile_decay_rle_cost_top
    import tdrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] texel_in, [15:8] decay_drop
    input  logic        i_s_tlast,   // last_texel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] texel_out, [8] tile_alive,
                                     // [23:9] nonzero_count, [38:24] encoded_bytes,
                                     // [39] thin_tile
    output logic        o_m_tuser    // stats_valid
);

    logic         r_in_valid;
    t_texel_item  r_in_item;
    logic         core_ready;
    t_tile_result core_result;

    // Input stage: take a transaction whenever it is empty or draining.
    assign o_s_tready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Hold the payload unless a new transaction lands.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.texel <= i_s_tdata[7:0];
            r_in_item.drop  <= i_s_tdata[15:8];
            r_in_item.last  <= i_s_tlast;
        end
    end

    tdrc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (core_ready),
        .i_item   (r_in_item),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (core_result)
    );

    // Pack the result fields, highest field first (thin_tile in the top bit).
    assign o_m_tdata = {core_result.thin_tile,
                        core_result.encoded_bytes,
                        core_result.nonzero_count,
                        core_result.tile_alive,
                        core_result.texel_out};
    assign o_m_tuser = core_result.stats_valid;

endmodule

/* hdl/tdrc_core.sv */
// Per-byte decay, run/pair and nonzero tracking, with the result register.
module tdrc_core
    import tdrc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_texel_item  i_item,
    output logic         o_valid,
    input  logic         i_ready,
    output t_tile_result o_result
);

    logic              r_first;
    logic [BYTE_W-1:0] r_prev;
    logic [BYTE_W-1:0] r_run;
    logic [CNT_W-1:0]  r_pairs;
    logic [CNT_W-1:0]  r_nonzero;
    logic              r_valid;
    t_tile_result      r_result;

    logic              n_first;
    logic [BYTE_W-1:0] n_prev;
    logic [BYTE_W-1:0] n_run;
    logic [CNT_W-1:0]  n_pairs;
    logic [CNT_W-1:0]  n_nonzero;
    t_tile_result      n_result;

    logic              fire;
    logic [BYTE_W-1:0] decayed;
    logic [ENC_W-1:0]  enc_full;
    logic [CNT_W-1:0]  enc_capped;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;
    assign decayed = (i_item.texel > i_item.drop) ? i_item.texel - i_item.drop : '0;

    always_comb begin
        n_first   = i_item.last;
        n_prev    = r_prev;
        n_run     = r_run;
        n_pairs   = r_pairs;
        n_nonzero = r_nonzero;
        if (r_first) begin
            n_pairs   = CNT_W'(1);
            n_nonzero = '0;
            n_run     = BYTE_W'(1);
            n_prev    = decayed;
        end else if (decayed == r_prev && r_run != BYTE_W'(RUN_MAX)) begin
            n_run = r_run + BYTE_W'(1);
        end else begin
            n_pairs = sat_inc(r_pairs);
            n_run   = BYTE_W'(1);
            n_prev  = decayed;
        end
        if (decayed != '0) begin
            n_nonzero = sat_inc(n_nonzero);
        end
    end

    // Cap the pair cost at the raw tile size.
    assign enc_full   = ENC_W'(n_pairs) * ENC_W'(PAIR_BYTES);
    assign enc_capped = (enc_full > ENC_W'(TEXELS)) ? CNT_W'(TEXELS) : enc_full[CNT_W-1:0];

    always_comb begin
        n_result             = '0;
        n_result.texel_out   = decayed;
        n_result.stats_valid = i_item.last;
        if (i_item.last) begin
            n_result.tile_alive    = (i_item.drop == '0) || (n_nonzero != '0);
            n_result.nonzero_count = n_nonzero;
            n_result.encoded_bytes = enc_capped;
            n_result.thin_tile     = ({1'b0, n_nonzero} < (CNT_W + 1)'(THIN_LIMIT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_prev    <= '0;
            r_run     <= '0;
            r_pairs   <= '0;
            r_nonzero <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_first   <= n_first;
                r_prev    <= n_prev;
                r_run     <= n_run;
                r_pairs   <= n_pairs;
                r_nonzero <= n_nonzero;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hdl/tdrc_checker.sv */
// Port-level assertions for the tile decay and run-length cost block, with bind.
module tdrc_checker
    import tdrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser
);

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Summary fields are zero on non-final bytes.
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[39:8] == '0)
        else $error("summary fields set on a non-final byte");

    // Encoded size never exceeds the raw tile size.
    a_enc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> {1'b0, o_m_tdata[38:24]} <= (CNT_W + 1)'(TEXELS))
        else $error("encoded size above tile size");

    // Any nonzero byte keeps the tile alive, and thin follows the count.
    a_alive_thin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[23:9] == '0 || o_m_tdata[8]) &&
            (o_m_tdata[39] == ({1'b0, o_m_tdata[23:9]} < (CNT_W + 1)'(THIN_LIMIT))))
        else $error("alive or thin flag inconsistent with nonzero count");

    // An empty output side always lets the input in.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

endmodule

bind tile_decay_rle_cost_top tdrc_checker u_tdrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
